>>> rtl/poly1305_mac_top_macros.svh
// assertion macros for the poly1305 authenticator checker
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef POLY1305_MAC_TOP_MACROS_SVH
`define POLY1305_MAC_TOP_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define P1305_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("p1305 check failed");

// next-cycle implication, checked on every rising edge out of reset
`define P1305_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("p1305 check failed");

`endif

>>> rtl/p1305_pkg.sv
// shared types, widths, clamp constants and the microcode table of the
// poly1305 authenticator; no dependencies
package p1305_pkg;

    // limb and datapath widths
    localparam int LIMB_W = 26;
    localparam int D_W    = 28;           // accumulator limb plus message limb
    localparam int C_W    = 29;           // clamped r limb times five
    localparam int P_W    = D_W + C_W;    // one partial product
    localparam int S_W    = 62;           // one row sum plus carry in
    localparam int K_W    = S_W - LIMB_W; // carry between rows
    localparam int PC_W   = 4;
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 64;

    // clamp masks of the r limbs
    localparam logic [LIMB_W-1:0] CLAMP0 = 26'h3ffffff;
    localparam logic [LIMB_W-1:0] CLAMP1 = 26'h3ffff03;
    localparam logic [LIMB_W-1:0] CLAMP2 = 26'h3ffc0ff;
    localparam logic [LIMB_W-1:0] CLAMP3 = 26'h3f03fff;
    localparam logic [LIMB_W-1:0] CLAMP4 = 26'h00fffff;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] REG_R_LOW  = 2'd0;
    localparam logic [CFG_IW-1:0] REG_R_HIGH = 2'd1;
    localparam logic [CFG_IW-1:0] REG_S_LOW  = 2'd2;
    localparam logic [CFG_IW-1:0] REG_S_HIGH = 2'd3;

    // full block byte count
    localparam logic [4:0] CNT_FULL = 5'd16;

    typedef struct packed {
        logic [63:0] block_lo;
        logic [63:0] block_hi;
        logic [4:0]  byte_count;
        logic        last;
    } t_in_req;

    typedef struct packed {
        logic [63:0] tag_lo;
        logic [63:0] tag_hi;
    } t_out_req;

    // sequencing of one control word
    typedef enum logic [1:0] {
        SEQ_NEXT  = 2'd0,  // step on
        SEQ_JZ    = 2'd1,  // jump to target on an empty block
        SEQ_ENDNL = 2'd2,  // finish unless this is the last block
        SEQ_END   = 2'd3   // finish
    } t_seq;

    typedef struct packed {
        logic            load;      // d = acc + message limbs
        logic            mul_en;    // products of one row
        logic [2:0]      mul_row;
        logic            sum_en;    // sum and carry of one row
        logic [2:0]      sum_row;
        logic            fold;      // top carry times five into limb 0
        logic            fin_norm;  // final carry pass
        logic            fin_sel;   // subtract p where it fits
        logic            tag_wr;    // add s, load tag, clear accumulator
        logic            wait_out;  // hold while the output is full
        t_seq            seq;
        logic [PC_W-1:0] target;
    } t_ctl;

    typedef struct packed {
        logic cnt_zero;
        logic last;
    } t_stat;

    localparam t_ctl CTL_NOP = '{
        load: 1'b0, mul_en: 1'b0, mul_row: 3'd0, sum_en: 1'b0, sum_row: 3'd0,
        fold: 1'b0, fin_norm: 1'b0, fin_sel: 1'b0, tag_wr: 1'b0,
        wait_out: 1'b0, seq: SEQ_END, target: '0
    };

    // step addresses of the program
    localparam logic [PC_W-1:0] PC_LOAD  = 4'd0;
    localparam logic [PC_W-1:0] PC_ROW0  = 4'd1;
    localparam logic [PC_W-1:0] PC_ROW1  = 4'd2;
    localparam logic [PC_W-1:0] PC_ROW2  = 4'd3;
    localparam logic [PC_W-1:0] PC_ROW3  = 4'd4;
    localparam logic [PC_W-1:0] PC_ROW4  = 4'd5;
    localparam logic [PC_W-1:0] PC_SUM4  = 4'd6;
    localparam logic [PC_W-1:0] PC_FOLD  = 4'd7;
    localparam logic [PC_W-1:0] PC_CHECK = 4'd8;
    localparam logic [PC_W-1:0] PC_NORM  = 4'd9;
    localparam logic [PC_W-1:0] PC_SEL   = 4'd10;
    localparam logic [PC_W-1:0] PC_TAG   = 4'd11;

    // microcode table
    function automatic t_ctl rom(input logic [PC_W-1:0] pc);
        t_ctl cw;
        cw     = CTL_NOP;
        cw.seq = SEQ_NEXT;
        unique case (pc)
            PC_LOAD: begin
                cw.load   = 1'b1;
                cw.seq    = SEQ_JZ;
                cw.target = PC_CHECK;
            end
            PC_ROW0: begin
                cw.mul_en  = 1'b1;
                cw.mul_row = 3'd0;
            end
            PC_ROW1: begin
                cw.mul_en  = 1'b1;
                cw.mul_row = 3'd1;
                cw.sum_en  = 1'b1;
                cw.sum_row = 3'd0;
            end
            PC_ROW2: begin
                cw.mul_en  = 1'b1;
                cw.mul_row = 3'd2;
                cw.sum_en  = 1'b1;
                cw.sum_row = 3'd1;
            end
            PC_ROW3: begin
                cw.mul_en  = 1'b1;
                cw.mul_row = 3'd3;
                cw.sum_en  = 1'b1;
                cw.sum_row = 3'd2;
            end
            PC_ROW4: begin
                cw.mul_en  = 1'b1;
                cw.mul_row = 3'd4;
                cw.sum_en  = 1'b1;
                cw.sum_row = 3'd3;
            end
            PC_SUM4: begin
                cw.sum_en  = 1'b1;
                cw.sum_row = 3'd4;
            end
            PC_FOLD: begin
                cw.fold = 1'b1;
            end
            PC_CHECK: begin
                cw.seq = SEQ_ENDNL;
            end
            PC_NORM: begin
                cw.fin_norm = 1'b1;
            end
            PC_SEL: begin
                cw.fin_sel = 1'b1;
            end
            PC_TAG: begin
                cw.tag_wr   = 1'b1;
                cw.wait_out = 1'b1;
                cw.seq      = SEQ_END;
            end
            default: begin
                cw = CTL_NOP;
            end
        endcase
        return cw;
    endfunction

endpackage

>>> rtl/poly1305_mac_top.sv
// poly1305 authenticator, one 16-byte block per request. A non-final block
// runs from acceptance to the next acceptance through capture, load, five
// rows on five shared multipliers, last row sum, top fold and end check. A final
// block goes on through the final carry pass, the trial subtraction and the tag
// step, which waits while the output is stalled; an empty request jumps from load to the end check.
// Synchronous active-low reset clears keys, accumulator, sequencer and output valid.
module poly1305_mac_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [p1305_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [p1305_pkg::CFG_DW-1:0] i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  p1305_pkg::t_in_req           i_in,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output p1305_pkg::t_out_req          o_out
);

    logic                 busy;
    logic                 accept;
    logic                 out_busy;
    p1305_pkg::t_ctl      ctl;
    p1305_pkg::t_stat     stat;
    p1305_pkg::t_out_req  tag;
    logic                 r_out_valid;
    p1305_pkg::t_out_req  r_out;

    // request handshake
    assign o_in_stall = busy;
    assign accept     = i_in_valid && !busy;
    assign out_busy   = r_out_valid && i_out_stall;

    p1305_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_out_busy (out_busy),
        .i_stat     (stat),
        .o_busy     (busy),
        .o_ctl      (ctl)
    );

    p1305_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_in        (i_in),
        .i_ctl       (ctl),
        .o_stat      (stat),
        .o_tag       (tag)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.tag_wr) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.tag_wr) begin
            r_out <= tag;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> rtl/p1305_seq.sv
// microcode sequencer: step counter, control table lookup and jumps
// depends on p1305_pkg
module p1305_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic             i_out_busy,
    input  p1305_pkg::t_stat i_stat,
    output logic             o_busy,
    output p1305_pkg::t_ctl  o_ctl
);

    logic [p1305_pkg::PC_W-1:0] r_pc;
    logic                       r_busy;
    p1305_pkg::t_ctl            cw;
    logic                       run;

    // current control word, held back while the tag cannot be delivered
    always_comb begin
        cw    = p1305_pkg::rom(r_pc);
        run   = r_busy && !(cw.wait_out && i_out_busy);
        o_ctl = run ? cw : p1305_pkg::CTL_NOP;
    end

    assign o_busy = r_busy;

    // step counter and program end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= '0;
        end else if (i_accept) begin
            r_busy <= 1'b1;
            r_pc   <= p1305_pkg::PC_LOAD;
        end else if (run) begin
            unique case (cw.seq)
                p1305_pkg::SEQ_NEXT: begin
                    r_pc <= r_pc + 1'b1;
                end
                p1305_pkg::SEQ_JZ: begin
                    r_pc <= i_stat.cnt_zero ? cw.target : r_pc + 1'b1;
                end
                p1305_pkg::SEQ_ENDNL: begin
                    if (!i_stat.last) begin
                        r_busy <= 1'b0;
                    end
                    r_pc <= r_pc + 1'b1;
                end
                p1305_pkg::SEQ_END: begin
                    r_busy <= 1'b0;
                end
                default: begin
                    r_busy <= 1'b0;
                end
            endcase
        end
    end

endmodule

>>> rtl/p1305_dp.sv
// datapath: key registers, block padding, row multiplier, accumulator,
// final reduction and tag adder; depends on p1305_pkg
module p1305_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [p1305_pkg::CFG_IW-1:0]     i_cfg_index,
    input  logic [p1305_pkg::CFG_DW-1:0]     i_cfg_data,
    input  logic                             i_accept,
    input  p1305_pkg::t_in_req               i_in,
    input  p1305_pkg::t_ctl                  i_ctl,
    output p1305_pkg::t_stat                 o_stat,
    output p1305_pkg::t_out_req              o_tag
);

    localparam int LW  = p1305_pkg::LIMB_W;
    localparam int F_W = p1305_pkg::K_W + 4;

    // key registers
    logic [63:0] r_rlo, r_rhi, r_slo, r_shi;

    // request registers
    logic [127:0] r_blk;
    logic [4:0]   r_cnt;
    logic         r_last;

    // accumulator limbs, limb 1 keeps one spare bit
    logic [LW-1:0] r_h0, r_h2, r_h3, r_h4;
    logic [LW:0]   r_h1;

    // working registers
    logic [p1305_pkg::D_W-1:0] r_d [5];
    logic [p1305_pkg::P_W-1:0] r_p [5];
    logic [p1305_pkg::K_W-1:0] r_carry;

    // combinational terms
    logic [LW-1:0]             rl [5];
    logic [p1305_pkg::C_W-1:0] rr [5];
    logic [p1305_pkg::C_W-1:0] rs [5];
    logic [p1305_pkg::C_W-1:0] cf [5];
    logic [128:0]              msg;
    logic [p1305_pkg::D_W-1:0] ml [5];
    logic [p1305_pkg::S_W-1:0] row_sum;
    logic [F_W-1:0]            h0_fold;
    logic [LW:0]               a2, a3, a4, a0, a1;
    logic [LW:0]               g0, g2, g3, g4s;
    logic [LW+1:0]             g1;
    logic                      take;
    logic [63:0]               pk_lo, pk_hi;
    logic [64:0]               t_lo;

    // clamped r limbs and their multiples of five
    always_comb begin
        rl[0] = r_rlo[25:0] & p1305_pkg::CLAMP0;
        rl[1] = r_rlo[51:26] & p1305_pkg::CLAMP1;
        rl[2] = {r_rhi[13:0], r_rlo[63:52]} & p1305_pkg::CLAMP2;
        rl[3] = r_rhi[39:14] & p1305_pkg::CLAMP3;
        rl[4] = {2'b00, r_rhi[63:40]} & p1305_pkg::CLAMP4;
        for (int i = 0; i < 5; i++) begin
            rr[i] = p1305_pkg::C_W'(rl[i]);
            rs[i] = (p1305_pkg::C_W'(rl[i]) << 2) + p1305_pkg::C_W'(rl[i]);
        end
    end

    // padded block: data bytes, then a 0x01 byte or the high bit
    always_comb begin
        for (int b = 0; b < 16; b++) begin
            if (5'(b) < r_cnt) begin
                msg[8*b +: 8] = r_blk[8*b +: 8];
            end else if (5'(b) == r_cnt) begin
                msg[8*b +: 8] = 8'h01;
            end else begin
                msg[8*b +: 8] = 8'h00;
            end
        end
        msg[128] = (r_cnt == p1305_pkg::CNT_FULL);
        ml[0] = p1305_pkg::D_W'(msg[25:0]);
        ml[1] = p1305_pkg::D_W'(msg[51:26]);
        ml[2] = p1305_pkg::D_W'(msg[77:52]);
        ml[3] = p1305_pkg::D_W'(msg[103:78]);
        ml[4] = p1305_pkg::D_W'(msg[128:104]);
    end

    // coefficient of each lane for the selected row
    always_comb begin
        for (int j = 0; j < 5; j++) begin
            if (j <= int'(i_ctl.mul_row)) begin
                cf[j] = rr[3'(int'(i_ctl.mul_row) - j)];
            end else begin
                cf[j] = rs[3'(int'(i_ctl.mul_row) + 5 - j)];
            end
        end
    end

    // row sum with the carry of the row below
    always_comb begin
        row_sum = (i_ctl.sum_row == 3'd0) ? '0 : p1305_pkg::S_W'(r_carry);
        for (int j = 0; j < 5; j++) begin
            row_sum = row_sum + p1305_pkg::S_W'(r_p[j]);
        end
        h0_fold = F_W'(r_h0) + (F_W'(r_carry) << 2) + F_W'(r_carry);
    end

    // final carry pass
    always_comb begin
        a2 = {1'b0, r_h2} + (LW+1)'(r_h1[LW]);
        a3 = {1'b0, r_h3} + (LW+1)'(a2[LW]);
        a4 = {1'b0, r_h4} + (LW+1)'(a3[LW]);
        a0 = {1'b0, r_h0} + ((LW+1)'(a4[LW]) << 2) + (LW+1)'(a4[LW]);
        a1 = {1'b0, r_h1[LW-1:0]} + (LW+1)'(a0[LW]);
    end

    // trial subtraction of 2^130-5
    always_comb begin
        g0   = {1'b0, r_h0} + (LW+1)'(5);
        g1   = {1'b0, r_h1} + (LW+2)'(g0[LW]);
        g2   = {1'b0, r_h2} + (LW+1)'(g1[LW+1:LW]);
        g3   = {1'b0, r_h3} + (LW+1)'(g2[LW]);
        g4s  = {1'b0, r_h4} + (LW+1)'(g3[LW]);
        take = g4s[LW];
    end

    // pack the limbs and add s
    always_comb begin
        pk_lo = 64'(r_h0) | (64'(r_h1) << 26) | (64'(r_h2) << 52);
        pk_hi = (64'(r_h2) >> 12) | (64'(r_h3) << 14) | (64'(r_h4) << 40);
        t_lo  = {1'b0, pk_lo} + {1'b0, r_slo};
        o_tag.tag_lo = t_lo[63:0];
        o_tag.tag_hi = pk_hi + r_shi + 64'(t_lo[64]);
    end

    assign o_stat.cnt_zero = (r_cnt == 5'd0);
    assign o_stat.last     = r_last;

    // key register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rlo <= '0;
            r_rhi <= '0;
            r_slo <= '0;
            r_shi <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                p1305_pkg::REG_R_LOW:  r_rlo <= i_cfg_data;
                p1305_pkg::REG_R_HIGH: r_rhi <= i_cfg_data;
                p1305_pkg::REG_S_LOW:  r_slo <= i_cfg_data;
                p1305_pkg::REG_S_HIGH: r_shi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // request capture, count saturated to a full block
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_blk  <= {i_in.block_hi, i_in.block_lo};
            r_cnt  <= (i_in.byte_count > p1305_pkg::CNT_FULL) ? p1305_pkg::CNT_FULL
                                                             : i_in.byte_count;
            r_last <= i_in.last;
        end
    end

    // operand load and row products
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_d[0] <= p1305_pkg::D_W'(r_h0) + ml[0];
            r_d[1] <= p1305_pkg::D_W'(r_h1) + ml[1];
            r_d[2] <= p1305_pkg::D_W'(r_h2) + ml[2];
            r_d[3] <= p1305_pkg::D_W'(r_h3) + ml[3];
            r_d[4] <= p1305_pkg::D_W'(r_h4) + ml[4];
        end
        if (i_ctl.mul_en) begin
            for (int j = 0; j < 5; j++) begin
                r_p[j] <= p1305_pkg::P_W'(r_d[j]) * p1305_pkg::P_W'(cf[j]);
            end
        end
        if (i_ctl.sum_en) begin
            r_carry <= row_sum[p1305_pkg::S_W-1:LW];
        end
    end

    // accumulator updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h0 <= '0;
            r_h1 <= '0;
            r_h2 <= '0;
            r_h3 <= '0;
            r_h4 <= '0;
        end else if (i_ctl.tag_wr) begin
            r_h0 <= '0;
            r_h1 <= '0;
            r_h2 <= '0;
            r_h3 <= '0;
            r_h4 <= '0;
        end else if (i_ctl.sum_en) begin
            unique case (i_ctl.sum_row)
                3'd0: r_h0 <= row_sum[LW-1:0];
                3'd1: r_h1 <= {1'b0, row_sum[LW-1:0]};
                3'd2: r_h2 <= row_sum[LW-1:0];
                3'd3: r_h3 <= row_sum[LW-1:0];
                3'd4: r_h4 <= row_sum[LW-1:0];
                default: ;
            endcase
        end else if (i_ctl.fold) begin
            r_h0 <= h0_fold[LW-1:0];
            r_h1 <= r_h1 + (LW+1)'(h0_fold[F_W-1:LW]);
        end else if (i_ctl.fin_norm) begin
            r_h0 <= a0[LW-1:0];
            r_h1 <= a1;
            r_h2 <= a2[LW-1:0];
            r_h3 <= a3[LW-1:0];
            r_h4 <= a4[LW-1:0];
        end else if (i_ctl.fin_sel && take) begin
            r_h0 <= g0[LW-1:0];
            r_h1 <= {1'b0, g1[LW-1:0]};
            r_h2 <= g2[LW-1:0];
            r_h3 <= g3[LW-1:0];
            r_h4 <= g4s[LW-1:0];
        end
    end

endmodule

>>> rtl/p1305_chk.sv
// port-level checker for the poly1305 authenticator, bound to the top level
// depends on p1305_pkg and poly1305_mac_top_macros.svh
`include "poly1305_mac_top_macros.svh"

module p1305_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input p1305_pkg::t_in_req           i_in,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input p1305_pkg::t_out_req          o_out
);

    logic in_acc;
    logic in_empty;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign in_empty = (i_in.byte_count == 5'd0) && !i_in.last;

    // an accepted request keeps the block busy
    `P1305_ASSERT_NXT(a_busy_after_req, in_acc, o_in_stall)

    // an empty non-final request frees the block after two steps
    `P1305_ASSERT_IMP(a_empty_quick, in_acc && in_empty, ##3 !o_in_stall)

    // a tag only appears at the end of work on a request
    `P1305_ASSERT_IMP(a_tag_from_work, $rose(o_out_valid), $past(o_in_stall))

    // a stalled tag stays put
    `P1305_ASSERT_NXT(a_tag_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out))

endmodule

bind poly1305_mac_top p1305_chk u_p1305_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

>>> tb/sv/poly1305_mac_checker.sv
// tag checker for the poly1305 authenticator: watches the key port, the request
// channel and the tag channel, predicts every tag and compares it; needs p1305_pkg
`timescale 1ns / 100ps

module poly1305_mac_checker
    import p1305_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  t_in_req           i_in,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  t_out_req          i_out,
    output int unsigned       o_pending,
    output int unsigned       o_errors
);

    localparam logic [63:0] LIMB_MASK   = (64'd1 << LIMB_W) - 64'd1;
    localparam logic [31:0] LIMB_MASK32 = LIMB_MASK[31:0];

    // key copy and accumulator limbs
    logic [63:0] key_r_lo, key_r_hi, key_s_lo, key_s_hi;
    logic [31:0] acc [5];
    t_out_req    expected_tags [$];
    int unsigned err_count = 0;

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("%0t poly1305 check: %s got %h want %h", $time, what, got, want);
        err_count++;
    endtask

    // one padded block into the accumulator: (acc + block) * r, partly carried
    task automatic absorb_block(input logic [63:0] lo, input logic [63:0] hi,
                                input int unsigned cnt);
        logic [63:0] r0, r1, r2, r3, r4, s1, s2, s3, s4;
        logic [63:0] m0, m1, m2, m3, m4, d0, d1, d2, d3, d4;
        logic [63:0] c0, c1, c2, c3, c4, h0;
        int unsigned k;
        r0 = key_r_lo & LIMB_MASK & CLAMP0;
        r1 = (key_r_lo >> 26) & LIMB_MASK & CLAMP1;
        r2 = ((key_r_lo >> 52) | (key_r_hi << 12)) & LIMB_MASK & CLAMP2;
        r3 = (key_r_hi >> 14) & LIMB_MASK & CLAMP3;
        r4 = (key_r_hi >> 40) & LIMB_MASK & CLAMP4;
        s1 = r1 * 5;
        s2 = r2 * 5;
        s3 = r3 * 5;
        s4 = r4 * 5;

        // short block: keep the counted bytes, then the 0x01 marker
        if (cnt < 8) begin
            lo = (lo & ((64'd1 << (8 * cnt)) - 64'd1)) | (64'd1 << (8 * cnt));
            hi = '0;
        end else if (cnt < 16) begin
            k = cnt - 8;
            if (k == 0) begin
                hi = 64'd1;
            end else begin
                hi = (hi & ((64'd1 << (8 * k)) - 64'd1)) | (64'd1 << (8 * k));
            end
        end

        m0 = lo & LIMB_MASK;
        m1 = (lo >> 26) & LIMB_MASK;
        m2 = ((lo >> 52) | (hi << 12)) & LIMB_MASK;
        m3 = (hi >> 14) & LIMB_MASK;
        m4 = (hi >> 40) & LIMB_MASK;
        if (cnt == 16) begin
            m4 = m4 + (64'd1 << 24);
        end

        d0 = {32'b0, acc[0]} + m0;
        d1 = {32'b0, acc[1]} + m1;
        d2 = {32'b0, acc[2]} + m2;
        d3 = {32'b0, acc[3]} + m3;
        d4 = {32'b0, acc[4]} + m4;

        c0 = d0 * r0 + d1 * s4 + d2 * s3 + d3 * s2 + d4 * s1;
        c1 = d0 * r1 + d1 * r0 + d2 * s4 + d3 * s3 + d4 * s2;
        c2 = d0 * r2 + d1 * r1 + d2 * r0 + d3 * s4 + d4 * s3;
        c3 = d0 * r3 + d1 * r2 + d2 * r1 + d3 * r0 + d4 * s4;
        c4 = d0 * r4 + d1 * r3 + d2 * r2 + d3 * r1 + d4 * r0;

        // carry chain, top carry folded back times five
        c1 = c1 + (c0 >> LIMB_W);
        acc[0] = 32'(c0 & LIMB_MASK);
        c2 = c2 + (c1 >> LIMB_W);
        acc[1] = 32'(c1 & LIMB_MASK);
        c3 = c3 + (c2 >> LIMB_W);
        acc[2] = 32'(c2 & LIMB_MASK);
        c4 = c4 + (c3 >> LIMB_W);
        acc[3] = 32'(c3 & LIMB_MASK);
        acc[4] = 32'(c4 & LIMB_MASK);
        h0 = {32'b0, acc[0]} + (c4 >> LIMB_W) * 5;
        acc[0] = 32'(h0 & LIMB_MASK);
        acc[1] = acc[1] + 32'(h0 >> LIMB_W);
    endtask

    // full reduction mod 2^130-5, then s added mod 2^128
    function automatic t_out_req close_tag();
        logic [31:0] h0, h1, h2, h3, h4, g0, g1, g2, g3, g4, c, take, keep;
        logic [63:0] lo, hi, sum;
        t_out_req tag;
        h0 = acc[0];
        h1 = acc[1];
        h2 = acc[2];
        h3 = acc[3];
        h4 = acc[4];
        c = h1 >> LIMB_W; h1 = h1 & LIMB_MASK32; h2 = h2 + c;
        c = h2 >> LIMB_W; h2 = h2 & LIMB_MASK32; h3 = h3 + c;
        c = h3 >> LIMB_W; h3 = h3 & LIMB_MASK32; h4 = h4 + c;
        c = h4 >> LIMB_W; h4 = h4 & LIMB_MASK32; h0 = h0 + c * 5;
        c = h0 >> LIMB_W; h0 = h0 & LIMB_MASK32; h1 = h1 + c;

        // h + 5 - 2^130, kept only where it does not go negative
        g0 = h0 + 32'd5;
        g1 = h1 + (g0 >> LIMB_W); g0 = g0 & LIMB_MASK32;
        g2 = h2 + (g1 >> LIMB_W); g1 = g1 & LIMB_MASK32;
        g3 = h3 + (g2 >> LIMB_W); g2 = g2 & LIMB_MASK32;
        g4 = h4 + (g3 >> LIMB_W) - (32'd1 << LIMB_W); g3 = g3 & LIMB_MASK32;
        take = (g4 >> 31) - 32'd1;
        keep = ~take;
        h0 = (h0 & keep) | (g0 & take);
        h1 = (h1 & keep) | (g1 & take);
        h2 = (h2 & keep) | (g2 & take);
        h3 = (h3 & keep) | (g3 & take);
        h4 = (h4 & keep) | (g4 & take);

        lo = {32'b0, h0} | ({32'b0, h1} << 26) | ({32'b0, h2} << 52);
        hi = ({32'b0, h2} >> 12) | ({32'b0, h3} << 14) | ({32'b0, h4} << 40);
        sum = lo + key_s_lo;
        tag.tag_lo = sum;
        tag.tag_hi = hi + key_s_hi + {63'b0, (sum < lo)};
        return tag;
    endfunction

    // one accepted request: absorb unless empty, tag on the last block
    task automatic take_request(input t_in_req req);
        int unsigned cnt;
        cnt = (req.byte_count > CNT_FULL) ? int'(CNT_FULL) : int'(req.byte_count);
        if (cnt != 0) begin
            absorb_block(req.block_lo, req.block_hi, cnt);
        end
        if (req.last) begin
            expected_tags.push_back(close_tag());
            for (int i = 0; i < 5; i++) begin
                acc[i] = '0;
            end
        end
    endtask

    // watch key writes, the request channel and the tag channel at every edge
    always @(posedge i_clk) begin : watch
        t_out_req want;
        if (!i_rst_n) begin
            key_r_lo = '0;
            key_r_hi = '0;
            key_s_lo = '0;
            key_s_hi = '0;
            for (int i = 0; i < 5; i++) begin
                acc[i] = '0;
            end
            expected_tags.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_R_LOW:  key_r_lo = i_cfg_data;
                    REG_R_HIGH: key_r_hi = i_cfg_data;
                    REG_S_LOW:  key_s_lo = i_cfg_data;
                    REG_S_HIGH: key_s_hi = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_tags.size() == 0) begin
                    flag_mismatch("tag with none expected", i_out.tag_lo, '0);
                end else begin
                    want = expected_tags.pop_front();
                    if (i_out.tag_lo !== want.tag_lo) begin
                        flag_mismatch("tag_lo", i_out.tag_lo, want.tag_lo);
                    end
                    if (i_out.tag_hi !== want.tag_hi) begin
                        flag_mismatch("tag_hi", i_out.tag_hi, want.tag_hi);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                take_request(i_in);
            end
        end
        o_pending <= expected_tags.size();
        o_errors  <= err_count;
    end

endmodule

>>> tb/sv/tb_top.sv
// top of the poly1305 authenticator testbench: clock, reset, key writes,
// block requests and output stalls; uses p1305_pkg and poly1305_mac_checker
`timescale 1ns / 100ps

module tb_top;
    import p1305_pkg::*;

    localparam int          HALF_PERIOD  = 10;
    localparam int          RESET_CYCLES = 9;
    localparam int          DRAIN_CYCLES = 30;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          N_PHASES     = 10;
    localparam int          RANDOM_ITEMS = 930;
    localparam int          LIMIT_NS     = 20_000_000;
    localparam logic [63:0] ONES         = '1;

    typedef enum int {KEY_ONES, KEY_ZERO, KEY_RANDOM, KEY_R_ONES, KEY_S_ONES} t_key_kind;
    typedef enum int {GAP_NONE, GAP_FULL, GAP_SPARSE} t_gap_mode;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [CFG_IW-1:0] i_cfg_index = '0;
    logic [CFG_DW-1:0] i_cfg_data  = '0;
    logic              i_in_valid  = 1'b0;
    t_in_req           i_in        = '0;
    logic              i_out_stall = 1'b0;
    logic              o_in_stall;
    logic              o_out_valid;
    t_out_req          o_out;

    int unsigned pending;
    int unsigned errors;
    t_gap_mode   gap_mode     = GAP_FULL;
    bit          hold_pending = 1'b0;
    int          sent         = 0;
    int          messages     = 0;
    int          settings     = 0;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    poly1305_mac_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    poly1305_mac_checker tag_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in        (i_in),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out       (o_out),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    function automatic int draw_gap();
        case (gap_mode)
            GAP_NONE: return 0;
            GAP_FULL: return int'($urandom_range(0, 19));
            default:  return ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 19)) : 0;
        endcase
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // one block request, held until accepted
    task automatic send_block(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [4:0] cnt, input logic lst);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in       <= '{block_lo: lo, block_hi: hi, byte_count: cnt, last: lst};
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        sent++;
        if (lst) begin
            messages++;
        end
    endtask

    task automatic await_tags();
        do @(posedge i_clk); while (pending != 0);
    endtask

    // block idle: no tag owed and the last block worked through
    task automatic quiesce();
        i_in_valid <= 1'b0;
        await_tags();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] index, input logic [63:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic load_key(input t_key_kind kind);
        logic [63:0] r_lo, r_hi, s_lo, s_hi;
        r_lo = rand_word();
        r_hi = rand_word();
        s_lo = rand_word();
        s_hi = rand_word();
        case (kind)
            KEY_ONES: begin
                r_lo = ONES; r_hi = ONES; s_lo = ONES; s_hi = ONES;
            end
            KEY_ZERO: begin
                r_lo = '0; r_hi = '0; s_lo = '0; s_hi = '0;
            end
            KEY_R_ONES: begin
                r_lo = ONES; r_hi = ONES;
            end
            KEY_S_ONES: begin
                s_lo = ONES; s_hi = ONES;
            end
            default: ;
        endcase
        write_reg(REG_R_LOW, r_lo);
        write_reg(REG_R_HIGH, r_hi);
        write_reg(REG_S_LOW, s_lo);
        write_reg(REG_S_HIGH, s_hi);
        i_cfg_we <= 1'b0;
        settings++;
    endtask

    // well-formed message: full blocks, then a final full, partial or empty one
    task automatic send_message(output int n);
        int          nblk;
        logic [4:0]  cnt;
        nblk = ($urandom_range(0, 9) < 7) ? int'($urandom_range(0, 3))
                                          : int'($urandom_range(4, 12));
        for (int i = 0; i < nblk; i++) begin
            send_block(rand_word(), rand_word(), CNT_FULL, 1'b0);
        end
        cnt = ($urandom_range(0, 2) == 0) ? CNT_FULL : 5'($urandom_range(1, 15));
        if (nblk == 0 && $urandom_range(0, 7) == 0) begin
            cnt = '0;
        end
        send_block(rand_word(), rand_word(), cnt, 1'b1);
        n = nblk + 1;
    endtask

    // any count and flag; an empty non-final request is ignored by the block
    task automatic send_noise(output int n);
        logic [4:0] cnt;
        logic       lst;
        cnt = 5'($urandom_range(0, 31));
        lst = 1'($urandom_range(0, 1));
        send_block(rand_word(), rand_word(), cnt, lst);
        n = (cnt == '0 && !lst) ? 0 : 1;
    endtask

    // output side: random stalls, one long hold-off on request
    initial begin : out_side
        int n;
        forever begin
            if (hold_pending) begin
                n = HOLD_CYCLES;
                hold_pending = 1'b0;
            end else begin
                n = draw_gap();
            end
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    initial begin : stimulus
        int count;
        int n;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset keys: empty message and one full block
        send_block('0, '0, '0, 1'b1);
        send_block(ONES, ONES, CNT_FULL, 1'b1);
        quiesce();

        // directed requests under the all-ones key
        load_key(KEY_ONES);
        send_block('0, '0, '0, 1'b1);
        send_block('0, '0, CNT_FULL, 1'b1);
        send_block(ONES, ONES, CNT_FULL, 1'b1);
        // every short count, stray bytes past the count set; even counts not final
        for (int c = 1; c < 16; c++) begin
            send_block(ONES, ONES, 5'(c), 1'(c % 2));
        end
        // oversized counts act as full blocks
        send_block(ONES, ONES, 5'd31, 1'b0);
        send_block(rand_word(), rand_word(), 5'd17, 1'b1);
        // empty final request after data: tag of the accumulator as it stands
        send_block(ONES, ONES, CNT_FULL, 1'b0);
        send_block('0, '0, '0, 1'b0);
        send_block('0, '0, '0, 1'b1);
        quiesce();

        // random phases over the key kinds and idling styles
        for (int ph = 0; ph < N_PHASES; ph++) begin
            load_key(t_key_kind'(ph % 5));
            gap_mode = t_gap_mode'(ph % 3);
            count = 0;
            if (ph == 4) begin
                // output held off while requests keep coming back to back
                hold_pending = 1'b1;
                gap_mode = GAP_NONE;
                repeat (24) begin
                    send_block(rand_word(), rand_word(), CNT_FULL, 1'b1);
                end
                count += 24;
                i_in_valid <= 1'b0;
                await_tags();
                gap_mode = GAP_SPARSE;
            end
            while (count < RANDOM_ITEMS / N_PHASES) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_noise(n);
                end else begin
                    send_message(n);
                end
                count += n;
            end
            quiesce();
        end

        $display("tb_top: %0d requests, %0d tagged messages, %0d key settings",
                 sent, messages, settings);
        $display("tb_top: short, full, oversized and empty blocks, gaps and output hold-off");
        if (errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_NS);
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

>>> poly1305_mac_top.f
+incdir+rtl
rtl/p1305_pkg.sv
rtl/p1305_seq.sv
rtl/p1305_dp.sv
rtl/poly1305_mac_top.sv
rtl/p1305_chk.sv
tb/sv/poly1305_mac_checker.sv
tb/sv/tb_top.sv
